FILE: design/multi_mode_process_scheduler_assert.svh
// Assertion macros for the multi-mode process scheduler.
// Used by the port checker; needs nothing else.
`ifndef MULTI_MODE_PROCESS_SCHEDULER_ASSERT_SVH
`define MULTI_MODE_PROCESS_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/mmps_pkg.sv
// Shared types, constants and helpers of the multi-mode process scheduler.
// Used by the slot table, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps

package mmps_pkg;

    // Table geometry and field widths.
    localparam int NUM_SLOTS = 5;
    localparam int SLOT_W    = 3;
    localparam int DATA_W    = 8;
    localparam int CNT_W     = $clog2(2 * NUM_SLOTS + 1);

    // Reset contents of the slot table.
    localparam logic [DATA_W-1:0] INIT_PRIORITY = DATA_W'(5);
    localparam logic [DATA_W-1:0] INIT_SHARE    = DATA_W'(1);

    typedef logic [SLOT_W-1:0] slot_t;

    // Selection modes held in the algorithm register.
    typedef enum logic [1:0] {
        MODE_RR    = 2'd0,
        MODE_LOW   = 2'd1,
        MODE_PRIO  = 2'd2,
        MODE_SHARE = 2'd3
    } mode_t;

    localparam mode_t MODE_RESET = MODE_SHARE;

    // Event codes.
    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_EXIT      = 2'd1,
        KIND_SET_PRI   = 2'd2,
        KIND_SET_SHARE = 2'd3
    } kind_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_TOP  = 2'd1,
        ST_WALK = 2'd2
    } state_t;

    // One slot as read from the table.
    typedef struct packed {
        logic              runnable;
        logic [DATA_W-1:0] priority_val;
        logic [DATA_W-1:0] share;
        logic [DATA_W-1:0] spent;
    } slot_rd_t;

    // Update command for one slot of the table.
    typedef struct packed {
        slot_t             idx;
        logic              clr_run;
        logic              wr_pri;
        logic              wr_share;
        logic              inc_spent;
        logic              clr_spent;
        logic [DATA_W-1:0] data;
    } slot_wr_t;

    // Slot after s, wrapping back to slot 0.
    function automatic slot_t next_of(input slot_t s);
        slot_t r;
        if (s == SLOT_W'(NUM_SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

endpackage

FILE: design/mmps_slot_tbl.sv
// Slot table of the scheduler: runnable marks, priorities, shares, spent counts.
// One read port and one update command per cycle; depends on mmps_pkg.
`timescale 1ns / 1ps

module mmps_slot_tbl (
    input  logic                clk,
    input  logic                rst_n,
    input  mmps_pkg::slot_t     rd_idx,
    output mmps_pkg::slot_rd_t  rd,
    input  mmps_pkg::slot_wr_t  wr
);

    logic                          run_reg   [mmps_pkg::NUM_SLOTS];
    logic [mmps_pkg::DATA_W-1:0]   pri_reg   [mmps_pkg::NUM_SLOTS];
    logic [mmps_pkg::DATA_W-1:0]   share_reg [mmps_pkg::NUM_SLOTS];
    logic [mmps_pkg::DATA_W-1:0]   spent_reg [mmps_pkg::NUM_SLOTS];

    // Read the slot that the sequencer points at.
    always_comb
    begin
        rd.runnable     = run_reg[rd_idx];
        rd.priority_val = pri_reg[rd_idx];
        rd.share        = share_reg[rd_idx];
        rd.spent        = spent_reg[rd_idx];
    end

    // Apply the update command; reset loads the start-up contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < mmps_pkg::NUM_SLOTS; s++)
            begin
                run_reg[s]   <= (s != 0);
                pri_reg[s]   <= mmps_pkg::INIT_PRIORITY;
                share_reg[s] <= mmps_pkg::INIT_SHARE;
                spent_reg[s] <= '0;
            end
        end
        else
        begin
            if (wr.clr_run)
            begin
                run_reg[wr.idx] <= 1'b0;
            end
            if (wr.wr_pri)
            begin
                pri_reg[wr.idx] <= wr.data;
            end
            if (wr.wr_share)
            begin
                share_reg[wr.idx] <= wr.data;
            end
            if (wr.inc_spent)
            begin
                spent_reg[wr.idx] <= spent_reg[wr.idx] + mmps_pkg::DATA_W'(1);
            end
            else if (wr.clr_spent)
            begin
                spent_reg[wr.idx] <= '0;
            end
        end
    end

endmodule

FILE: design/multi_mode_process_scheduler.sv
// Top level of the multi-mode process scheduler: sequencer, shared comparator, result.
// Depends on mmps_pkg and mmps_slot_tbl.
`timescale 1ns / 1ps

// Channel   | Signals                          | Transfer
// ----------+----------------------------------+-------------------------------
// event in  | start, busy, kind, value         | start high while busy low
// result    | done, next_slot, none_runnable   | done high, one cycle, no stall
// config    | cfg_valid, cfg_ready, algorithm  | cfg_valid and cfg_ready high
//
// A set-priority or set-share event answers in the next cycle.
// A tick or exit examines one slot per cycle with one shared 8-bit comparator;
// in highest priority, a pass that finds the top priority comes before the walk.
// busy stays high during the walk; the result strobe follows the last slot visited.
// Reset loads the slot table and the algorithm register with their start-up values.

module multi_mode_process_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] kind,
    input  logic [7:0] value,
    output logic       done,
    output logic [2:0] next_slot,
    output logic       none_runnable,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] algorithm
);

    mmps_pkg::state_t              state_reg, state_next;
    mmps_pkg::mode_t               mode_reg;
    mmps_pkg::slot_t               cur_reg, cur_next;
    mmps_pkg::slot_t               ptr_reg, ptr_next;
    logic [mmps_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [mmps_pkg::DATA_W-1:0]   top_reg, top_next;
    logic                          done_reg, done_next;
    mmps_pkg::slot_t               slot_out_reg, slot_out_next;
    logic                          none_reg, none_next;

    mmps_pkg::slot_rd_t            rd;
    mmps_pkg::slot_wr_t            wr;

    logic                          accept;
    logic                          last;
    logic                          hit;
    logic [mmps_pkg::DATA_W-1:0]   cmp_a, cmp_b;
    logic                          cmp_lt, cmp_eq;

    mmps_slot_tbl u_tbl (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (ptr_reg),
        .rd     (rd),
        .wr     (wr)
    );

    assign accept    = start && (state_reg == mmps_pkg::ST_IDLE);
    assign last      = (cnt_reg == mmps_pkg::CNT_W'(1));
    assign busy      = (state_reg != mmps_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done          = done_reg;
    assign next_slot     = slot_out_reg;
    assign none_runnable = none_reg;

    // Shared comparator: operands depend on the walk in progress.
    always_comb
    begin
        cmp_a = rd.spent;
        cmp_b = rd.share;
        if (state_reg == mmps_pkg::ST_TOP)
        begin
            cmp_a = top_reg;
            cmp_b = rd.priority_val;
        end
        else if (mode_reg == mmps_pkg::MODE_PRIO)
        begin
            cmp_a = rd.priority_val;
            cmp_b = top_reg;
        end
        cmp_lt = (cmp_a < cmp_b);
        cmp_eq = (cmp_a == cmp_b);
    end

    // A visited slot is chosen when it is runnable and passes the mode's test.
    always_comb
    begin
        case (mode_reg)
            mmps_pkg::MODE_PRIO:  hit = rd.runnable && cmp_eq;
            mmps_pkg::MODE_SHARE: hit = rd.runnable && cmp_lt;
            default:              hit = rd.runnable;
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmps_pkg::ST_IDLE:
            begin
                if (accept && (kind == mmps_pkg::KIND_TICK || kind == mmps_pkg::KIND_EXIT))
                begin
                    state_next = (mode_reg == mmps_pkg::MODE_PRIO) ? mmps_pkg::ST_TOP
                                                                   : mmps_pkg::ST_WALK;
                end
            end
            mmps_pkg::ST_TOP:
            begin
                if (last)
                begin
                    state_next = mmps_pkg::ST_WALK;
                end
            end
            mmps_pkg::ST_WALK:
            begin
                if (hit || last)
                begin
                    state_next = mmps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmps_pkg::ST_IDLE;
            end
        endcase
    end

    // Walk pointer, counters, table updates and result.
    always_comb
    begin
        cur_next      = cur_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        top_next      = top_reg;
        done_next     = 1'b0;
        slot_out_next = slot_out_reg;
        none_next     = none_reg;
        wr            = '0;
        wr.idx        = ptr_reg;
        wr.data       = value;

        unique case (state_reg)
            mmps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    wr.idx = cur_reg;
                    if (kind == mmps_pkg::KIND_SET_PRI || kind == mmps_pkg::KIND_SET_SHARE)
                    begin
                        // Parameter writes go to the current slot and answer with it.
                        wr.wr_pri      = (kind == mmps_pkg::KIND_SET_PRI);
                        wr.wr_share    = (kind == mmps_pkg::KIND_SET_SHARE);
                        done_next      = 1'b1;
                        slot_out_next  = cur_reg;
                        none_next      = 1'b0;
                    end
                    else
                    begin
                        wr.clr_run = (kind == mmps_pkg::KIND_EXIT);
                        top_next   = '0;
                        case (mode_reg)
                            mmps_pkg::MODE_RR:
                            begin
                                ptr_next = mmps_pkg::next_of(cur_reg);
                                cnt_next = mmps_pkg::CNT_W'(mmps_pkg::NUM_SLOTS);
                            end
                            mmps_pkg::MODE_SHARE:
                            begin
                                ptr_next = cur_reg;
                                cnt_next = mmps_pkg::CNT_W'(2 * mmps_pkg::NUM_SLOTS);
                            end
                            default:
                            begin
                                // Lowest index and the priority scan start at slot 1.
                                ptr_next = mmps_pkg::SLOT_W'(1);
                                cnt_next = mmps_pkg::CNT_W'(mmps_pkg::NUM_SLOTS - 1);
                            end
                        endcase
                    end
                end
            end
            mmps_pkg::ST_TOP:
            begin
                // Find the top priority among runnable slots.
                if (rd.runnable && cmp_lt)
                begin
                    top_next = rd.priority_val;
                end
                if (last)
                begin
                    ptr_next = mmps_pkg::next_of(cur_reg);
                    cnt_next = mmps_pkg::CNT_W'(mmps_pkg::NUM_SLOTS);
                end
                else
                begin
                    ptr_next = mmps_pkg::next_of(ptr_reg);
                    cnt_next = cnt_reg - mmps_pkg::CNT_W'(1);
                end
            end
            mmps_pkg::ST_WALK:
            begin
                if (hit)
                begin
                    wr.inc_spent  = (mode_reg == mmps_pkg::MODE_SHARE);
                    cur_next      = ptr_reg;
                    done_next     = 1'b1;
                    slot_out_next = ptr_reg;
                    none_next     = 1'b0;
                end
                else
                begin
                    // A passed slot loses its spent credits in proportional share.
                    wr.clr_spent = (mode_reg == mmps_pkg::MODE_SHARE);
                    ptr_next     = mmps_pkg::next_of(ptr_reg);
                    cnt_next     = cnt_reg - mmps_pkg::CNT_W'(1);
                    if (last)
                    begin
                        done_next     = 1'b1;
                        slot_out_next = cur_reg;
                        none_next     = 1'b1;
                    end
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmps_pkg::ST_IDLE;
            mode_reg  <= mmps_pkg::MODE_RESET;
            cur_reg   <= mmps_pkg::SLOT_W'(1);
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= mmps_pkg::mode_t'(algorithm);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        top_reg      <= top_next;
        slot_out_reg <= slot_out_next;
        none_reg     <= none_next;
    end

endmodule

FILE: design/mmps_check.sv
// Port checker for the multi-mode process scheduler, bound to the top level.
// Depends on mmps_pkg and multi_mode_process_scheduler_assert.svh.
`timescale 1ns / 1ps
`include "multi_mode_process_scheduler_assert.svh"

module mmps_check (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] kind,
    input logic       done,
    input logic [2:0] next_slot,
    input logic       none_runnable
);

    logic set_xfer;
    logic walk_xfer;

    assign set_xfer  = start && !busy &&
                       (kind == mmps_pkg::KIND_SET_PRI || kind == mmps_pkg::KIND_SET_SHARE);
    assign walk_xfer = start && !busy &&
                       (kind == mmps_pkg::KIND_TICK || kind == mmps_pkg::KIND_EXIT);

    // A reported slot is always a real slot other than the idle slot 0.
    `MMPS_ASSERT_SAME(a_slot_range, clk, rst_n, done,
        next_slot != 3'd0 && next_slot < mmps_pkg::SLOT_W'(mmps_pkg::NUM_SLOTS))
    // A parameter write answers in the next cycle and never reports an empty table.
    `MMPS_ASSERT_NEXT(a_set_answer, clk, rst_n, set_xfer, done && !none_runnable && !busy)
    // A tick or exit always starts a walk over the table.
    `MMPS_ASSERT_NEXT(a_walk_busy, clk, rst_n, walk_xfer, busy && !done)
    // A result closes the walk: the block is free once its strobe shows.
    `MMPS_ASSERT_SAME(a_done_free, clk, rst_n, done, !busy)

endmodule

bind multi_mode_process_scheduler mmps_check u_mmps_check (.*);

FILE: sim/slot_choice_checker.sv
`timescale 1ns / 1ps
// Checker for the multi-mode process scheduler: keeps its own copy of the slot table,
// predicts the slot chosen for every event and compares it with the block's results.
// Depends on mmps_pkg for the event and mode codes and the slot geometry.

import mmps_pkg::*;

module slot_choice_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] kind,
    input  logic [7:0] value,
    input  logic       done,
    input  logic [2:0] next_slot,
    input  logic       none_runnable,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] algorithm,
    output int         mismatches,
    output int         waiting,
    output int         empty_picks
);

    // Start-up contents of the table, written out independently of the RTL.
    localparam logic [7:0] PRI_AT_RESET   = 8'd5;
    localparam logic [7:0] SHARE_AT_RESET = 8'd1;

    typedef struct packed {
        slot_t slot;
        logic  none;
    } choice_t;

    mode_t      sched_mode;
    slot_t      running;
    logic       ready_mark [NUM_SLOTS];
    logic [7:0] prio_tbl   [NUM_SLOTS];
    logic [7:0] share_tbl  [NUM_SLOTS];
    logic [7:0] spent_tbl  [NUM_SLOTS];
    choice_t    expected_choices [$];

    initial
    begin
        mismatches  = 0;
        empty_picks = 0;
    end

    // One line per mismatch, and a running count for the verdict.
    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Slot after s, wrapping back to slot 0.
    function automatic slot_t wrap_next(input slot_t s);
        return (s == slot_t'(NUM_SLOTS - 1)) ? slot_t'(0) : slot_t'(s + 1'b1);
    endfunction

    // Apply one event to the table copy and work out the slot that runs next.
    task automatic choose_next_slot(input kind_t ev, input logic [7:0] arg,
                                    output choice_t res);
        slot_t      here;
        slot_t      s;
        logic       found;
        logic [7:0] top_pri;
        int         i;
        here     = (running < NUM_SLOTS) ? running : slot_t'(0);
        found    = 1'b0;
        res.slot = here;
        res.none = 1'b0;
        if (ev == KIND_SET_PRI)
        begin
            prio_tbl[here] = arg;
        end
        else if (ev == KIND_SET_SHARE)
        begin
            share_tbl[here] = arg;
        end
        else
        begin
            if (ev == KIND_EXIT)
            begin
                ready_mark[here] = 1'b0;
            end
            s = here;
            case (sched_mode)
                MODE_RR:
                begin
                    // The current slot is tried last.
                    for (i = 0; i < NUM_SLOTS && !found; i++)
                    begin
                        s = wrap_next(s);
                        found = ready_mark[s];
                    end
                end
                MODE_LOW:
                begin
                    for (i = 1; i < NUM_SLOTS && !found; i++)
                    begin
                        if (ready_mark[i])
                        begin
                            s     = slot_t'(i);
                            found = 1'b1;
                        end
                    end
                end
                MODE_PRIO:
                begin
                    // Find the top priority first, then take turns among the ties.
                    top_pri = 8'd0;
                    for (i = 1; i < NUM_SLOTS; i++)
                    begin
                        if (ready_mark[i] && prio_tbl[i] > top_pri)
                        begin
                            top_pri = prio_tbl[i];
                        end
                    end
                    for (i = 0; i < NUM_SLOTS && !found; i++)
                    begin
                        s = wrap_next(s);
                        found = ready_mark[s] && (prio_tbl[s] == top_pri);
                    end
                end
                default:
                begin
                    // Spend credit at the first slot that has some; clear every slot passed.
                    for (i = 0; i < 2 * NUM_SLOTS && !found; i++)
                    begin
                        if (ready_mark[s] && spent_tbl[s] < share_tbl[s])
                        begin
                            spent_tbl[s] = spent_tbl[s] + 8'd1;
                            found        = 1'b1;
                        end
                        else
                        begin
                            spent_tbl[s] = 8'd0;
                            s            = wrap_next(s);
                        end
                    end
                end
            endcase
            if (found)
            begin
                running  = s;
                res.slot = s;
            end
            else
            begin
                res.none = 1'b1;
            end
        end
    endtask

    // Follow configuration and event transfers, then check each result strobe.
    always @(posedge clk or negedge rst_n)
    begin : track
        choice_t want;
        int      n;
        if (!rst_n)
        begin
            sched_mode = MODE_SHARE;
            running    = slot_t'(1);
            for (n = 0; n < NUM_SLOTS; n++)
            begin
                ready_mark[n] = (n != 0);
                prio_tbl[n]   = PRI_AT_RESET;
                share_tbl[n]  = SHARE_AT_RESET;
                spent_tbl[n]  = 8'd0;
            end
            expected_choices.delete();
            waiting <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sched_mode = mode_t'(algorithm);
            end
            if (start && !busy)
            begin
                choose_next_slot(kind_t'(kind), value, want);
                expected_choices.push_back(want);
            end
            if (done)
            begin
                if (expected_choices.size() == 0)
                begin
                    report_mismatch($sformatf("result slot %0d with nothing expected",
                                              next_slot));
                end
                else
                begin
                    want = expected_choices.pop_front();
                    if (next_slot !== want.slot)
                    begin
                        report_mismatch($sformatf("next_slot got %0d expected %0d",
                                                  next_slot, want.slot));
                    end
                    if (none_runnable !== want.none)
                    begin
                        report_mismatch($sformatf("none_runnable got %0b expected %0b",
                                                  none_runnable, want.none));
                    end
                    if (want.none)
                    begin
                        empty_picks++;
                    end
                end
            end
            waiting <= expected_choices.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, event and mode stimulus, watchdog, verdict.
// Depends on mmps_pkg, multi_mode_process_scheduler and slot_choice_checker.

import mmps_pkg::*;

module tb_top;

    localparam int IDLE_LIMIT = 2000;
    localparam int ROUNDS     = 16;
    localparam int ROUND_LEN  = 50;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic [1:0] kind      = 2'd0;
    logic [7:0] value     = 8'd0;
    logic       cfg_valid = 1'b0;
    logic [1:0] algorithm = 2'd0;
    logic       busy;
    logic       done;
    logic [2:0] next_slot;
    logic       none_runnable;
    logic       cfg_ready;

    int mismatches;
    int waiting;
    int empty_picks;
    int events_sent  = 0;
    int modes_written = 0;
    int quiet_cycles = 0;
    bit gaps_on      = 1'b0;

    always #4 clk = ~clk;

    multi_mode_process_scheduler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .value         (value),
        .done          (done),
        .next_slot     (next_slot),
        .none_runnable (none_runnable),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .algorithm     (algorithm)
    );

    slot_choice_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .value         (value),
        .done          (done),
        .next_slot     (next_slot),
        .none_runnable (none_runnable),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .algorithm     (algorithm),
        .mismatches    (mismatches),
        .waiting       (waiting),
        .empty_picks   (empty_picks)
    );

    // Present one event and hold it until the block takes the transfer.
    // Called at a rising edge; returns at the edge of the transfer with start still high.
    task automatic send_event(input kind_t k, input logic [7:0] v);
        if (gaps_on && $urandom_range(99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        start <= 1'b1;
        kind  <= k;
        value <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        events_sent++;
    endtask

    // Stop sending and wait until every expected result is back and the block is idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (waiting != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    // Write the algorithm register; only called while the block is idle.
    task automatic write_mode(input mode_t m);
        if (gaps_on && $urandom_range(99) < 7)
        begin
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        algorithm <= m;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        modes_written++;
    endtask

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        int    r;
        int    i;
        int    exit_at;
        int    roll;
        mode_t m;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset mode is proportional share: zero share, full share, priority extremes.
        send_event(KIND_TICK, 8'hFF);
        send_event(KIND_TICK, 8'h00);
        send_event(KIND_SET_SHARE, 8'h00);
        send_event(KIND_TICK, 8'h5A);
        send_event(KIND_SET_SHARE, 8'hFF);
        send_event(KIND_TICK, 8'hA5);
        send_event(KIND_TICK, 8'h0F);
        send_event(KIND_SET_PRI, 8'hFF);
        send_event(KIND_SET_PRI, 8'h00);
        drain();

        // Round robin and lowest index on the full table.
        write_mode(MODE_RR);
        send_event(KIND_TICK, 8'h01);
        send_event(KIND_TICK, 8'h80);
        send_event(KIND_TICK, 8'h7F);
        drain();
        write_mode(MODE_LOW);
        send_event(KIND_TICK, 8'h33);
        send_event(KIND_TICK, 8'hCC);
        drain();

        // Highest priority, including the first exit of a slot.
        write_mode(MODE_PRIO);
        send_event(KIND_SET_PRI, 8'd200);
        send_event(KIND_TICK, 8'h00);
        send_event(KIND_TICK, 8'hFF);
        send_event(KIND_EXIT, 8'h55);
        send_event(KIND_TICK, 8'hAA);
        send_event(KIND_SET_SHARE, 8'd1);
        drain();

        // Random rounds, one mode each. Slots never come back after an exit,
        // so the remaining exits are spread out to keep most rounds busy.
        for (r = 0; r < ROUNDS; r++)
        begin
            gaps_on = !(r >= 4 && r < 8);
            m       = (r < 4) ? mode_t'(r) : mode_t'($urandom_range(0, 3));
            write_mode(m);
            exit_at = (r == 7 || r == 11 || r == 14) ? $urandom_range(0, ROUND_LEN - 1) : -1;
            for (i = 0; i < ROUND_LEN; i++)
            begin
                roll = $urandom_range(99);
                if (i == exit_at)
                begin
                    send_event(KIND_EXIT, 8'($urandom));
                end
                else if (roll < 60)
                begin
                    send_event(KIND_TICK, 8'($urandom));
                end
                else if (roll < 80)
                begin
                    // Mostly small priorities so that ties are common.
                    send_event(KIND_SET_PRI, ($urandom_range(99) < 80) ?
                               8'($urandom_range(0, 7)) : 8'($urandom));
                end
                else
                begin
                    // Mostly small shares so that credits run out and zero shares occur.
                    send_event(KIND_SET_SHARE, ($urandom_range(99) < 80) ?
                               8'($urandom_range(0, 3)) : 8'($urandom));
                end
            end
            drain();
        end

        // Nothing left to run: every kind of event in every mode.
        gaps_on = 1'b1;
        for (r = 0; r < 4; r++)
        begin
            write_mode(mode_t'(r));
            send_event(KIND_TICK, 8'($urandom));
            send_event(KIND_EXIT, 8'($urandom));
            send_event(KIND_SET_PRI, 8'($urandom));
            send_event(KIND_SET_SHARE, 8'($urandom));
            drain();
        end

        repeat (30) @(posedge clk);
        $display("Run covered %0d events under %0d mode writes, all four modes and kinds.",
                 events_sent, modes_written);
        $display("Slots were retired down to none; %0d results reported nothing runnable.",
                 empty_picks);
        if (mismatches == 0 && waiting == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
